[rtl/mte_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI track event encoder package
// Shared event codes, microcode format, sequencer program and divider sizes.
// ----------------------------------------------------------------------------
package mte_pkg;

   localparam int VLQ_BYTES_DEFAULT = 5;

   // Tempo divider: 60000000 fits in 26 bits; two quotient bits per cycle.
   localparam int                QUO_W          = 26;
   localparam logic [QUO_W-1:0]  TEMPO_DIVIDEND = 26'd60000000;
   localparam int                DIV_BITS       = 2;
   localparam int                DIV_STEPS      = QUO_W / DIV_BITS;
   localparam int                DIV_CNT_W      = $clog2(DIV_STEPS + 1);
   localparam int                BPM_W          = 16;
   localparam int                USEC_W         = 24;

   typedef enum logic [1:0] {
      OP_NOTE_ON  = 2'd0,
      OP_NOTE_OFF = 2'd1,
      OP_TEMPO    = 2'd2,
      OP_EOT      = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      SRC_CONST,
      SRC_VLQ,
      SRC_STATUS,
      SRC_PITCH,
      SRC_VEL,
      SRC_USEC_HI,
      SRC_USEC_MID,
      SRC_USEC_LO
   } src_type;

   typedef enum logic [1:0] {
      J_NEXT,
      J_VLQ,
      J_WAIT,
      J_END
   } jump_type;

   typedef struct packed {
      logic       emit;
      src_type    src;
      logic [7:0] const_byte;
      logic       last;
      logic       err;
      jump_type   jump;
   } ucode_type;

   typedef logic [3:0] step_type;

   localparam step_type STEP_ERR          = 4'd0;
   localparam step_type STEP_VLQ          = 4'd1;
   localparam step_type STEP_NOTE_STATUS  = 4'd2;
   localparam step_type STEP_NOTE_PITCH   = 4'd3;
   localparam step_type STEP_NOTE_VEL     = 4'd4;
   localparam step_type STEP_TEMPO_FF     = 4'd5;
   localparam step_type STEP_TEMPO_TYPE   = 4'd6;
   localparam step_type STEP_TEMPO_LEN    = 4'd7;
   localparam step_type STEP_TEMPO_WAIT   = 4'd8;
   localparam step_type STEP_TEMPO_HI     = 4'd9;
   localparam step_type STEP_TEMPO_MID    = 4'd10;
   localparam step_type STEP_TEMPO_LO     = 4'd11;
   localparam step_type STEP_EOT_FF       = 4'd12;
   localparam step_type STEP_EOT_TYPE     = 4'd13;
   localparam step_type STEP_EOT_LEN      = 4'd14;

   localparam logic [7:0] META_PREFIX     = 8'hff;
   localparam logic [7:0] META_SET_TEMPO  = 8'h51;
   localparam logic [7:0] META_TEMPO_LEN  = 8'h03;
   localparam logic [7:0] META_END_TRACK  = 8'h2f;
   localparam logic [7:0] META_EOT_LEN    = 8'h00;
   localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
   localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;

   // Sequencer program, one control word per step.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type cw;
      cw = '{emit: 1'b1, src: SRC_CONST, const_byte: 8'h00,
             last: 1'b0, err: 1'b0, jump: J_NEXT};
      unique case (step)
         STEP_ERR: begin
            cw.last = 1'b1; cw.err = 1'b1; cw.jump = J_END;
         end
         STEP_VLQ:         begin cw.src = SRC_VLQ; cw.jump = J_VLQ; end
         STEP_NOTE_STATUS: cw.src = SRC_STATUS;
         STEP_NOTE_PITCH:  cw.src = SRC_PITCH;
         STEP_NOTE_VEL: begin
            cw.src = SRC_VEL; cw.last = 1'b1; cw.jump = J_END;
         end
         STEP_TEMPO_FF:    cw.const_byte = META_PREFIX;
         STEP_TEMPO_TYPE:  cw.const_byte = META_SET_TEMPO;
         STEP_TEMPO_LEN:   cw.const_byte = META_TEMPO_LEN;
         STEP_TEMPO_WAIT:  begin cw.emit = 1'b0; cw.jump = J_WAIT; end
         STEP_TEMPO_HI:    cw.src = SRC_USEC_HI;
         STEP_TEMPO_MID:   cw.src = SRC_USEC_MID;
         STEP_TEMPO_LO: begin
            cw.src = SRC_USEC_LO; cw.last = 1'b1; cw.jump = J_END;
         end
         STEP_EOT_FF:      cw.const_byte = META_PREFIX;
         STEP_EOT_TYPE:    cw.const_byte = META_END_TRACK;
         STEP_EOT_LEN: begin
            cw.const_byte = META_EOT_LEN; cw.last = 1'b1; cw.jump = J_END;
         end
         default: begin
            cw.emit = 1'b0; cw.jump = J_END;
         end
      endcase
      return cw;
   endfunction

   // First body step of each event kind, taken after the last delta word.
   function automatic step_type body_entry(input op_type op);
      step_type step;
      unique case (op)
         OP_NOTE_ON, OP_NOTE_OFF: step = STEP_NOTE_STATUS;
         OP_TEMPO:                step = STEP_TEMPO_FF;
         OP_EOT:                  step = STEP_EOT_FF;
         default:                 step = STEP_EOT_FF;
      endcase
      return step;
   endfunction

endpackage
`default_nettype wire

[rtl/mte_tempo_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Tempo divider
// Restoring division of 60000000 by the tempo in bpm, two quotient bits a cycle.
// ----------------------------------------------------------------------------
module mte_tempo_div
   import mte_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              div_start,
   input  wire logic [BPM_W-1:0]  div_bpm,
   output logic                   div_done,
   output logic [USEC_W-1:0]      div_usec
);

   logic                  running_ff, running_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [BPM_W-1:0]      divisor_ff, divisor_in;
   logic [BPM_W-1:0]      rem_ff, rem_in;
   logic [QUO_W-1:0]      qd_ff, qd_in;

   // The dividend shifts out of the top of qd while quotient bits enter below.
   always_comb begin
      logic [BPM_W:0]   trial;
      logic [BPM_W-1:0] rem;
      logic [QUO_W-1:0] qd;
      rem        = rem_ff;
      qd         = qd_ff;
      running_in = running_ff;
      done_in    = done_ff;
      cnt_in     = cnt_ff;
      divisor_in = divisor_ff;
      for (int j = 0; j < DIV_BITS; j++) begin
         trial = {rem, qd[QUO_W-1]};
         qd    = {qd[QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            rem   = BPM_W'(trial - {1'b0, divisor_ff});
            qd[0] = 1'b1;
         end else begin
            rem = trial[BPM_W-1:0];
         end
      end
      rem_in = rem_ff;
      qd_in  = qd_ff;
      if (div_start) begin
         running_in = 1'b1;
         done_in    = 1'b0;
         cnt_in     = DIV_CNT_W'(DIV_STEPS);
         divisor_in = div_bpm;
         rem_in     = '0;
         qd_in      = TEMPO_DIVIDEND;
      end else if (running_ff) begin
         rem_in = rem;
         qd_in  = qd;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      qd_ff      <= qd_in;
   end

   assign div_done = done_ff;
   assign div_usec = qd_ff[USEC_W-1:0];

endmodule
`default_nettype wire

[rtl/midi_track_event_encoder_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI track event encoder
// Turns one track event request into its Standard MIDI File bytes.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low.
// The block then sends the event one word per cycle on rsp_out_byte, save for
// the tempo divider wait, each word marked by rsp_strobe for exactly one
// cycle; rsp_last flags the final word. The delta time goes first as a
// variable-length quantity, then the status and data bytes. A bad channel or
// pitch, or a zero tempo, gives one word with rsp_error and rsp_last set and
// a zero byte. After the accepting edge the first word is read from the step
// counter's control word and then registered onto the result ports. busy
// stays high while the delta words and the body bytes go out, or the error
// word of a rejected request, and falls as the final word is registered.
// On a set tempo event the tempo divider yields two quotient bits a cycle and
// runs while the delta and meta header words go out; the sequencer waits for
// it before the tempo bytes, and busy stays high through the wait.
// The receiver cannot stall; words leave one per cycle but for the divider wait.
// Reset returns the sequencer and divider to idle; no word is in flight after.
// ----------------------------------------------------------------------------
module midi_track_event_encoder_top
   import mte_pkg::*;
#(
   parameter int MAX_VLQ_BYTES = VLQ_BYTES_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic [1:0]   req_op,
   input  wire logic [31:0]  req_delta_ticks,
   input  wire logic [7:0]   req_channel,
   input  wire logic [7:0]   req_pitch,
   input  wire logic [7:0]   req_velocity,
   input  wire logic [15:0]  req_tempo_bpm,
   output logic              rsp_strobe,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last,
   output logic              rsp_error
);

   localparam int VLQ_BITS = 7 * MAX_VLQ_BYTES;
   localparam int GRP_W    = $clog2(MAX_VLQ_BYTES + 1);
   localparam int IDX_W    = (MAX_VLQ_BYTES > 1) ? $clog2(MAX_VLQ_BYTES) : 1;

   logic                  active_ff, active_in;
   step_type              pc_ff, pc_in;
   logic [GRP_W-1:0]      grp_ff, grp_in;
   logic [VLQ_BITS-1:0]   delta_ff;
   op_type                op_ff;
   logic [3:0]            chan_ff;
   logic [6:0]            pitch_ff;
   logic [6:0]            vel_ff;
   logic                  strobe_ff, strobe_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  last_ff, last_in;
   logic                  error_ff, error_in;

   logic                  accept;
   logic                  reject;
   op_type                req_kind;
   logic [VLQ_BITS-1:0]   delta_ext;
   logic [GRP_W-1:0]      ngroups;
   logic [6:0]            grp_bits [MAX_VLQ_BYTES];
   logic [IDX_W-1:0]      grp_idx;
   ucode_type             cw;
   logic                  div_done;
   logic [USEC_W-1:0]     div_usec;

   assign busy     = active_ff;
   assign accept   = start & ~active_ff;
   assign req_kind = op_type'(req_op);
   assign delta_ext = VLQ_BITS'(req_delta_ticks);

   always_comb begin
      reject = 1'b0;
      unique case (req_kind)
         OP_NOTE_ON, OP_NOTE_OFF: reject = (req_channel > 8'd15) || req_pitch[7];
         OP_TEMPO:                reject = (req_tempo_bpm == '0);
         OP_EOT:                  reject = 1'b0;
         default:                 reject = 1'b0;
      endcase
   end

   // Number of delta words: the highest nonzero seven-bit group, at least one.
   always_comb begin
      ngroups = GRP_W'(1);
      for (int g = 1; g < MAX_VLQ_BYTES; g++) begin
         if (delta_ext[7*g +: 7] != 7'd0) begin
            ngroups = GRP_W'(g + 1);
         end
      end
   end

   always_comb begin
      for (int g = 0; g < MAX_VLQ_BYTES; g++) begin
         grp_bits[g] = delta_ff[7*g +: 7];
      end
   end

   assign grp_idx = IDX_W'(grp_ff - 1'b1);
   assign cw      = ucode_rom(pc_ff);

   always_comb begin
      byte_in = cw.const_byte;
      unique case (cw.src)
         SRC_CONST:    byte_in = cw.const_byte;
         SRC_VLQ:      byte_in = {(grp_ff > GRP_W'(1)), grp_bits[grp_idx]};
         SRC_STATUS:   byte_in = {(op_ff == OP_NOTE_ON) ? STATUS_NOTE_ON
                                                        : STATUS_NOTE_OFF, chan_ff};
         SRC_PITCH:    byte_in = {1'b0, pitch_ff};
         SRC_VEL:      byte_in = {1'b0, vel_ff};
         SRC_USEC_HI:  byte_in = div_usec[23:16];
         SRC_USEC_MID: byte_in = div_usec[15:8];
         SRC_USEC_LO:  byte_in = div_usec[7:0];
         default:      byte_in = cw.const_byte;
      endcase
   end

   // Sequencer: step counter with the jump kinds of the control word.
   always_comb begin
      active_in = active_ff;
      pc_in     = pc_ff;
      grp_in    = grp_ff;
      strobe_in = 1'b0;
      last_in   = cw.last;
      error_in  = cw.err;
      if (accept) begin
         active_in = 1'b1;
         pc_in     = reject ? STEP_ERR : STEP_VLQ;
         grp_in    = ngroups;
      end else if (active_ff) begin
         strobe_in = cw.emit;
         unique case (cw.jump)
            J_NEXT: pc_in = pc_ff + 1'b1;
            J_VLQ: begin
               if (grp_ff > GRP_W'(1)) begin
                  grp_in = grp_ff - 1'b1;
               end else begin
                  pc_in = body_entry(op_ff);
               end
            end
            J_WAIT: begin
               if (div_done) begin
                  pc_in = pc_ff + 1'b1;
               end
            end
            J_END: active_in = 1'b0;
            default: active_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff    <= pc_in;
      grp_ff   <= grp_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      error_ff <= error_in;
      if (accept) begin
         delta_ff <= delta_ext;
         op_ff    <= req_kind;
         chan_ff  <= req_channel[3:0];
         pitch_ff <= req_pitch[6:0];
         vel_ff   <= req_velocity[7] ? 7'h7f : req_velocity[6:0];
      end
   end

   mte_tempo_div u_tempo_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (accept && (req_kind == OP_TEMPO)),
      .div_bpm   (req_tempo_bpm),
      .div_done  (div_done),
      .div_usec  (div_usec)
   );

   assign rsp_strobe   = strobe_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;
   assign rsp_error    = error_ff;

endmodule
`default_nettype wire

[sim/tb_midi_track_event_encoder_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI track event encoder testbench
// Sends note, tempo and end-of-track requests, directed and random, predicts
// the encoded words of each accepted request and checks every strobed word.
// ----------------------------------------------------------------------------
module tb_midi_track_event_encoder_top;
   import mte_pkg::*;

   localparam int          VLQ_BYTES      = VLQ_BYTES_DEFAULT;
   localparam int          VLQ_BITS       = 7 * VLQ_BYTES;
   localparam int unsigned USEC_PER_MIN   = 32'd60000000;
   localparam int unsigned USEC_MASK      = 32'h00ffffff;
   localparam logic [7:0]  VLQ_MORE       = 8'h80;
   localparam logic [7:0]  VLQ_GROUP      = 8'h7f;
   localparam logic [7:0]  VEL_MAX        = 8'd127;
   localparam logic [7:0]  PITCH_MAX      = 8'd127;
   localparam logic [7:0]  CHANNEL_MAX    = 8'd15;
   localparam int          DRAIN_CYCLES   = 24;
   localparam int          RANDOM_ITEMS   = 160;
   localparam int          STEADY_ITEMS   = 30;

   typedef struct packed {
      logic [7:0] byte_val;
      logic       last;
      logic       err;
   } event_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = OP_NOTE_ON;
   logic [31:0] req_delta_ticks = '0;
   logic [7:0]  req_channel = '0;
   logic [7:0]  req_pitch = '0;
   logic [7:0]  req_velocity = '0;
   logic [15:0] req_tempo_bpm = '0;
   logic        rsp_strobe;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic        rsp_error;

   event_word_type pending_words[$];
   int             fail_count = 0;
   bit             idle_on = 1'b1;

   midi_track_event_encoder_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_delta_ticks (req_delta_ticks),
      .req_channel     (req_channel),
      .req_pitch       (req_pitch),
      .req_velocity    (req_velocity),
      .req_tempo_bpm   (req_tempo_bpm),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last),
      .rsp_error       (rsp_error)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   task automatic push_word(input logic [7:0] val, input logic last, input logic err);
      pending_words.push_back('{byte_val: val, last: last, err: err});
   endtask

   // Builds the SMF words of one accepted request: delta VLQ, then the body, or a single error word if it is rejected.
   task automatic predict_event_words(input logic [1:0] op_bits, input logic [31:0] delta,
                                      input logic [7:0] channel, input logic [7:0] pitch,
                                      input logic [7:0] velocity, input logic [15:0] bpm);
      op_type      op;
      logic [63:0] delta_w;
      int          ngroups;
      logic [7:0]  body[6];
      int          nbody;
      logic [7:0]  grp;
      int unsigned usec;
      op = op_type'(op_bits);
      delta_w = {32'b0, delta} & ((64'd1 << VLQ_BITS) - 64'd1);
      nbody = 0;
      unique case (op)
         OP_NOTE_ON, OP_NOTE_OFF: begin
            if (channel > CHANNEL_MAX || pitch > PITCH_MAX) begin
               push_word(8'h00, 1'b1, 1'b1);
               return;
            end
            body[0] = {(op == OP_NOTE_ON) ? STATUS_NOTE_ON : STATUS_NOTE_OFF, channel[3:0]};
            body[1] = pitch;
            body[2] = (velocity > VEL_MAX) ? VEL_MAX : velocity;
            nbody = 3;
         end
         OP_TEMPO: begin
            if (bpm == 16'd0) begin
               push_word(8'h00, 1'b1, 1'b1);
               return;
            end
            usec = (USEC_PER_MIN / bpm) & USEC_MASK;
            body[0] = META_PREFIX;
            body[1] = META_SET_TEMPO;
            body[2] = META_TEMPO_LEN;
            body[3] = usec[23:16];
            body[4] = usec[15:8];
            body[5] = usec[7:0];
            nbody = 6;
         end
         default: begin
            body[0] = META_PREFIX;
            body[1] = META_END_TRACK;
            body[2] = META_EOT_LEN;
            nbody = 3;
         end
      endcase
      ngroups = 1;
      while (ngroups < VLQ_BYTES && (delta_w >> (7 * ngroups)) != 64'd0)
         ngroups++;
      for (int g = ngroups; g > 0; g--) begin
         grp = 8'(delta_w >> (7 * (g - 1))) & VLQ_GROUP;
         if (g > 1)
            grp = grp | VLQ_MORE;
         push_word(grp, 1'b0, 1'b0);
      end
      for (int i = 0; i < nbody; i++)
         push_word(body[i], (i == nbody - 1), 1'b0);
   endtask

   // Takes the request on each accepting edge and checks each strobed word.
   always @(posedge clock) begin : word_checker
      event_word_type got;
      event_word_type want;
      if (!reset) begin
         if (start && !busy)
            predict_event_words(req_op, req_delta_ticks, req_channel, req_pitch,
                                req_velocity, req_tempo_bpm);
         if (rsp_strobe) begin
            got = '{byte_val: rsp_out_byte, last: rsp_last, err: rsp_error};
            if (pending_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word byte=%02h last=%0b error=%0b",
                                         got.byte_val, got.last, got.err));
            end else begin
               want = pending_words.pop_front();
               if (got.byte_val != want.byte_val)
                  report_mismatch($sformatf("byte %02h, expected %02h",
                                            got.byte_val, want.byte_val));
               if (got.last != want.last)
                  report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
               if (got.err != want.err)
                  report_mismatch($sformatf("error %0b, expected %0b", got.err, want.err));
            end
         end
      end
   end

   // Holds start high until the request is taken; start stays high afterwards.
   task automatic send_event(input op_type op, input logic [31:0] delta,
                             input logic [7:0] channel, input logic [7:0] pitch,
                             input logic [7:0] velocity, input logic [15:0] bpm);
      @(negedge clock);
      start <= 1'b1;
      req_op <= op;
      req_delta_ticks <= delta;
      req_channel <= channel;
      req_pitch <= pitch;
      req_velocity <= velocity;
      req_tempo_bpm <= bpm;
      do
         @(posedge clock);
      while (busy);
   endtask

   task automatic idle_cycles(input int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic maybe_idle();
      if (idle_on && $urandom_range(0, 99) < 35)
         idle_cycles($urandom_range(1, 19));
   endtask

   // Mostly valid events with delta lengths spread over every VLQ size.
   task automatic send_random_event();
      op_type      op;
      logic [31:0] delta;
      logic [7:0]  channel;
      logic [7:0]  pitch;
      logic [15:0] bpm;
      int          width;
      op = op_type'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
         0: delta = 32'd1 << (7 * $urandom_range(1, 4));
         1: delta = (32'd1 << (7 * $urandom_range(1, 4))) - 32'd1;
         default: begin
            width = $urandom_range(0, 32);
            delta = (width == 0) ? 32'd0 : ($urandom() >> (32 - width));
         end
      endcase
      channel = ($urandom_range(0, 99) < 88) ? 8'($urandom_range(0, 15))
                                             : 8'($urandom_range(16, 255));
      pitch = ($urandom_range(0, 99) < 88) ? 8'($urandom_range(0, 127))
                                           : 8'($urandom_range(128, 255));
      case ($urandom_range(0, 19))
         0: bpm = 16'd0;
         1: bpm = 16'($urandom_range(1, 3));
         default: bpm = 16'($urandom_range(1, 65535));
      endcase
      send_event(op, delta, channel, pitch, 8'($urandom_range(0, 255)), bpm);
   endtask

   task automatic test_note_events();
      send_event(OP_NOTE_ON,  32'd0,          8'd0,  8'd0,   8'd0,   16'd0);
      send_event(OP_NOTE_ON,  32'd127,        8'd15, 8'd127, 8'd127, 16'd0);
      send_event(OP_NOTE_OFF, 32'd128,        8'd7,  8'd60,  8'd128, 16'd120);
      send_event(OP_NOTE_OFF, 32'hffff_ffff,  8'd15, 8'd127, 8'd255, 16'hffff);
      send_event(OP_NOTE_ON,  32'd16383,      8'd9,  8'd64,  8'd100, 16'd1);
   endtask

   task automatic test_rejected_events();
      send_event(OP_NOTE_ON,  32'd5,          8'd16,  8'd60,  8'd90,  16'd120);
      send_event(OP_NOTE_ON,  32'd5,          8'd3,   8'd128, 8'd90,  16'd120);
      send_event(OP_NOTE_OFF, 32'hffff_ffff,  8'd255, 8'd255, 8'd255, 16'hffff);
      send_event(OP_TEMPO,    32'd300,        8'd0,   8'd0,   8'd0,   16'd0);
   endtask

   task automatic test_tempo_events();
      // Tempos of 1 to 3 bpm overflow the 24-bit tempo field.
      send_event(OP_TEMPO, 32'd0,         8'd0,   8'd0,   8'd0,   16'd1);
      send_event(OP_TEMPO, 32'd1,         8'd0,   8'd0,   8'd0,   16'd2);
      send_event(OP_TEMPO, 32'd2,         8'd0,   8'd0,   8'd0,   16'd3);
      send_event(OP_TEMPO, 32'd16384,     8'd0,   8'd0,   8'd0,   16'd4);
      send_event(OP_TEMPO, 32'd2097151,   8'd255, 8'd255, 8'd255, 16'd120);
      send_event(OP_TEMPO, 32'hffff_ffff, 8'd0,   8'd0,   8'd0,   16'hffff);
   endtask

   task automatic test_end_of_track();
      send_event(OP_EOT, 32'd0,          8'd255, 8'd255, 8'd255, 16'd0);
      send_event(OP_EOT, 32'd2097152,    8'd0,   8'd0,   8'd0,   16'd0);
      send_event(OP_EOT, 32'd268435455,  8'd0,   8'd0,   8'd0,   16'd77);
      send_event(OP_EOT, 32'd268435456,  8'd20,  8'd200, 8'd0,   16'd0);
   endtask

   task automatic test_random_with_gaps();
      repeat (RANDOM_ITEMS) begin
         maybe_idle();
         send_random_event();
      end
   endtask

   // The sender holds off until every word of the queued requests has come out.
   task automatic test_drain_pause();
      repeat (6) begin
         maybe_idle();
         send_random_event();
      end
      @(negedge clock);
      start <= 1'b0;
      while (pending_words.size() != 0)
         @(negedge clock);
      repeat (6) send_random_event();
   endtask

   task automatic test_random_back_to_back();
      idle_on = 1'b0;
      repeat (STEADY_ITEMS) send_random_event();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_note_events();
      test_rejected_events();
      test_tempo_events();
      test_end_of_track();
      test_random_with_gaps();
      test_drain_pause();
      test_random_back_to_back();

      @(negedge clock);
      start <= 1'b0;
      while (pending_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d words outstanding", pending_words.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
